// ===== src/ehp_pkg.sv =====
// Shared types, constants and helpers for the Ethernet/IP header parser.
// Used by ehp_capture, ehp_finish and ethernet_ip_header_parser.
// No dependencies.
`timescale 1ns / 1ps

package ehp_pkg;

    // Width of the per-frame byte counter (saturates at all ones)
    localparam int FRAME_LENGTH_BITS = 16;
    // Width used for length compares: counter or 16-bit IP length fields
    localparam int CMP_W = (FRAME_LENGTH_BITS > 16) ? FRAME_LENGTH_BITS : 16;

    // Ethertypes
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_VLAN = 16'h8100;

    // Network header start offsets
    localparam logic [4:0] NS_ETHERNET = 5'd14;
    localparam logic [4:0] NS_COOKED   = 5'd16;
    localparam logic [4:0] NS_TAGGED   = 5'd18;

    // IP protocol numbers
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    // Link type register values
    localparam logic LINK_ETHERNET = 1'b0;
    localparam logic LINK_COOKED   = 1'b1;

    // Register index of link_type on the APB port
    localparam logic REG_LINK_TYPE = 1'b0;

    // Result status codes
    localparam logic [1:0] ST_ACCEPT    = 2'd0;
    localparam logic [1:0] ST_REJECT    = 2'd1;
    localparam logic [1:0] ST_ARP_SHORT = 2'd2;

    // Network kinds
    localparam logic [1:0] NET_IPV4 = 2'd0;
    localparam logic [1:0] NET_IPV6 = 2'd1;
    localparam logic [1:0] NET_ARP  = 2'd2;
    localparam logic [1:0] NET_NONE = 2'd3;

    // Transport kinds
    localparam logic [2:0] TR_TCP   = 3'd0;
    localparam logic [2:0] TR_UDP   = 3'd1;
    localparam logic [2:0] TR_ICMP  = 3'd2;
    localparam logic [2:0] TR_OTHER = 3'd3;
    localparam logic [2:0] TR_NONE  = 3'd4;

    // Everything the finish stage needs about one frame
    typedef struct packed {
        logic [FRAME_LENGTH_BITS-1:0] cap_len;
        logic [15:0] ethertype;
        logic [4:0]  net_start;
        logic [7:0]  first_byte;
        logic [15:0] declared_len;
        logic [7:0]  protocol;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] arp_op;
    } frame_summary_t;

    // One result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  network_kind;
        logic [2:0]  transport_kind;
        logic [7:0]  ip_protocol;
        logic [6:0]  l4_offset;
        logic [15:0] l4_length;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [15:0] arp_operation;
    } result_t;

    function automatic logic [2:0] transport_class(input logic [7:0] proto);
        logic [2:0] kind;
        case (proto)
            PROTO_TCP:               kind = TR_TCP;
            PROTO_UDP:               kind = TR_UDP;
            PROTO_ICMP, PROTO_ICMPV6: kind = TR_ICMP;
            default:                 kind = TR_OTHER;
        endcase
        return kind;
    endfunction

endpackage

// ===== src/ethernet_ip_header_parser.sv =====
// Top level of the Ethernet/cooked-capture to IPv4/IPv6/ARP header parser.
// Instantiates ehp_capture and ehp_finish; depends on ehp_pkg.
`timescale 1ns / 1ps

// Takes one frame byte per clock on the s_ channel and returns one result
// transaction on the m_ channel for each frame, after the byte marked
// s_last_byte. A byte is accepted every cycle as long as the result side
// keeps up. The last byte is loaded into the input register when it is
// accepted, then passes the frame summary register and the output
// register, whose valid flag drives m_valid. Back pressure on m_ready
// holds the pipeline only when a finished frame is waiting behind an
// untaken result. The link_type register (APB byte address 0) selects
// Ethernet or 16-byte Linux cooked framing; it is sampled at the first
// byte of each frame and should be written only while no frame is in
// flight.

module ethernet_ip_header_parser (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Frame byte stream
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_frame_byte,
    input  logic        s_last_byte,

    // Result stream
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [1:0]  m_network_kind,
    output logic [2:0]  m_transport_kind,
    output logic [7:0]  m_ip_protocol,
    output logic [6:0]  m_l4_offset,
    output logic [15:0] m_l4_length,
    output logic [63:0] m_source_high,
    output logic [63:0] m_source_low,
    output logic [63:0] m_dest_high,
    output logic [63:0] m_dest_low,
    output logic [15:0] m_arp_operation
);

    logic       link_type_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       step;
    logic       sum_valid;
    logic       sum_ready;
    logic       sum_free;
    logic       cfg_write;
    ehp_pkg::frame_summary_t summary;
    ehp_pkg::result_t        result;

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == ehp_pkg::REG_LINK_TYPE);
    assign prdata    = (paddr[2] == ehp_pkg::REG_LINK_TYPE) ? {31'd0, link_type_reg} : 32'd0;

    // Input register drains unless a last byte finds the summary stage full and not being taken
    assign sum_free = !sum_valid || sum_ready;
    assign step     = in_valid_reg && (!in_last_reg || sum_free);
    assign s_ready  = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_type_reg <= ehp_pkg::LINK_ETHERNET;
            in_valid_reg  <= 1'b0;
        end else begin
            if (cfg_write) begin
                link_type_reg <= pwdata[0];
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_frame_byte;
            in_last_reg <= s_last_byte;
        end
    end

    ehp_capture u_capture (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .frame_byte (in_byte_reg),
        .last_byte  (in_last_reg),
        .link_type  (link_type_reg),
        .sum_take   (sum_ready),
        .sum_valid  (sum_valid),
        .summary    (summary)
    );

    ehp_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sum_valid (sum_valid),
        .summary   (summary),
        .sum_ready (sum_ready),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .result    (result)
    );

    assign m_status         = result.status;
    assign m_network_kind   = result.network_kind;
    assign m_transport_kind = result.transport_kind;
    assign m_ip_protocol    = result.ip_protocol;
    assign m_l4_offset      = result.l4_offset;
    assign m_l4_length      = result.l4_length;
    assign m_source_high    = result.source_high;
    assign m_source_low     = result.source_low;
    assign m_dest_high      = result.dest_high;
    assign m_dest_low       = result.dest_low;
    assign m_arp_operation  = result.arp_operation;

endmodule

// ===== src/ehp_capture.sv =====
// Byte-position tracker and header field capture for one frame at a time.
// On the last byte it latches a frame summary for the finish stage.
// Depends on ehp_pkg.
`timescale 1ns / 1ps

module ehp_capture (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,        // consume one byte this cycle
    input  logic [7:0]            frame_byte,
    input  logic                  last_byte,
    input  logic                  link_type,
    input  logic                  sum_take,    // finish stage takes the summary
    output logic                  sum_valid,
    output ehp_pkg::frame_summary_t summary
);

    localparam int FLB = ehp_pkg::FRAME_LENGTH_BITS;
    localparam logic [FLB-1:0] POS_MAX = {FLB{1'b1}};

    logic [FLB-1:0] pos_reg,    pos_next;
    logic [15:0]    etype_reg,  etype_next;
    logic [4:0]     ns_reg,     ns_next;
    logic [7:0]     fnb_reg,    fnb_next;
    logic [15:0]    decl_reg,   decl_next;
    logic [7:0]     proto_reg,  proto_next;
    logic [63:0]    src_hi_reg, src_hi_next;
    logic [63:0]    src_lo_reg, src_lo_next;
    logic [63:0]    dst_hi_reg, dst_hi_next;
    logic [63:0]    dst_lo_reg, dst_lo_next;
    logic [15:0]    arp_reg,    arp_next;
    logic [FLB-1:0] cap_len;
    logic           sum_valid_reg, sum_valid_next;
    ehp_pkg::frame_summary_t summary_reg;

    // Working values: cleared at frame start (network start reloaded from link_type)
    logic           frame_start;
    logic [15:0]    etype_cur;
    logic [4:0]     ns_cur;
    logic [7:0]     fnb_cur, proto_cur;
    logic [15:0]    decl_cur, arp_cur;
    logic [63:0]    src_hi_cur, src_lo_cur, dst_hi_cur, dst_lo_cur;
    logic           sll;
    logic           in_net;
    logic [FLB-1:0] q_full;
    logic [5:0]     q;
    logic           q_small;

    always_comb begin
        frame_start = (pos_reg == '0);
        etype_cur  = frame_start ? 16'd0 : etype_reg;
        ns_cur     = frame_start ? ((link_type == ehp_pkg::LINK_COOKED) ?
                                    ehp_pkg::NS_COOKED : ehp_pkg::NS_ETHERNET) : ns_reg;
        fnb_cur    = frame_start ? 8'd0  : fnb_reg;
        decl_cur   = frame_start ? 16'd0 : decl_reg;
        proto_cur  = frame_start ? 8'd0  : proto_reg;
        src_hi_cur = frame_start ? 64'd0 : src_hi_reg;
        src_lo_cur = frame_start ? 64'd0 : src_lo_reg;
        dst_hi_cur = frame_start ? 64'd0 : dst_hi_reg;
        dst_lo_cur = frame_start ? 64'd0 : dst_lo_reg;
        arp_cur    = frame_start ? 16'd0 : arp_reg;
        sll        = (ns_cur == ehp_pkg::NS_COOKED);

        // Link-layer ethertype (plain, cooked, or inner after a tag)
        etype_next = etype_cur;
        if ((!sll && (pos_reg == FLB'(12) || pos_reg == FLB'(13))) ||
            (sll && (pos_reg == FLB'(14) || pos_reg == FLB'(15))) ||
            (!sll && ns_cur == ehp_pkg::NS_TAGGED &&
             (pos_reg == FLB'(16) || pos_reg == FLB'(17)))) begin
            etype_next = {etype_cur[7:0], frame_byte};
        end

        // 802.1Q tag moves the network header
        ns_next = ns_cur;
        if (!sll && pos_reg == FLB'(13) && etype_next == ehp_pkg::ETH_VLAN) begin
            ns_next = ehp_pkg::NS_TAGGED;
        end

        // Offset within the network header
        in_net  = (pos_reg >= FLB'(ns_next));
        q_full  = pos_reg - FLB'(ns_next);
        q       = q_full[5:0];
        q_small = in_net && (q_full[FLB-1:6] == '0);

        fnb_next    = fnb_cur;
        decl_next   = decl_cur;
        proto_next  = proto_cur;
        src_hi_next = src_hi_cur;
        src_lo_next = src_lo_cur;
        dst_hi_next = dst_hi_cur;
        dst_lo_next = dst_lo_cur;
        arp_next    = arp_cur;

        // Network header field capture
        if (q_small) begin
            if (q == 6'd0) begin
                fnb_next = frame_byte;
            end
            if (etype_next == ehp_pkg::ETH_IPV4) begin
                if (q == 6'd2 || q == 6'd3) decl_next = {decl_cur[7:0], frame_byte};
                if (q == 6'd9) proto_next = frame_byte;
                if (q >= 6'd12 && q <= 6'd15) src_lo_next = {src_lo_cur[55:0], frame_byte};
                if (q >= 6'd16 && q <= 6'd19) dst_lo_next = {dst_lo_cur[55:0], frame_byte};
            end else if (etype_next == ehp_pkg::ETH_IPV6) begin
                if (q == 6'd4 || q == 6'd5) decl_next = {decl_cur[7:0], frame_byte};
                if (q == 6'd6) proto_next = frame_byte;
                if (q >= 6'd8 && q <= 6'd15) src_hi_next = {src_hi_cur[55:0], frame_byte};
                if (q >= 6'd16 && q <= 6'd23) src_lo_next = {src_lo_cur[55:0], frame_byte};
                if (q >= 6'd24 && q <= 6'd31) dst_hi_next = {dst_hi_cur[55:0], frame_byte};
                if (q >= 6'd32 && q <= 6'd39) dst_lo_next = {dst_lo_cur[55:0], frame_byte};
            end else if (etype_next == ehp_pkg::ETH_ARP) begin
                if (q == 6'd6 || q == 6'd7) arp_next = {arp_cur[7:0], frame_byte};
                if (q >= 6'd14 && q <= 6'd17) src_lo_next = {src_lo_cur[55:0], frame_byte};
                if (q >= 6'd24 && q <= 6'd27) dst_lo_next = {dst_lo_cur[55:0], frame_byte};
            end
        end

        // Saturating captured length; counter restarts after the last byte
        cap_len  = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + FLB'(1);
        pos_next = last_byte ? '0 : cap_len;

        sum_valid_next = (sum_valid_reg && !sum_take) || (step && last_byte);
    end

    // Frame state and summary register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            sum_valid_reg <= 1'b0;
        end else begin
            sum_valid_reg <= sum_valid_next;
            if (step) begin
                pos_reg <= pos_next;
            end
        end
        if (step) begin
            etype_reg  <= etype_next;
            ns_reg     <= ns_next;
            fnb_reg    <= fnb_next;
            decl_reg   <= decl_next;
            proto_reg  <= proto_next;
            src_hi_reg <= src_hi_next;
            src_lo_reg <= src_lo_next;
            dst_hi_reg <= dst_hi_next;
            dst_lo_reg <= dst_lo_next;
            arp_reg    <= arp_next;
        end
        if (step && last_byte) begin
            summary_reg.cap_len      <= cap_len;
            summary_reg.ethertype    <= etype_next;
            summary_reg.net_start    <= ns_next;
            summary_reg.first_byte   <= fnb_next;
            summary_reg.declared_len <= decl_next;
            summary_reg.protocol     <= proto_next;
            summary_reg.src_hi       <= src_hi_next;
            summary_reg.src_lo       <= src_lo_next;
            summary_reg.dst_hi       <= dst_hi_next;
            summary_reg.dst_lo       <= dst_lo_next;
            summary_reg.arp_op       <= arp_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign summary   = summary_reg;

endmodule

// ===== src/ehp_finish.sv =====
// Frame classification and layer-4 span from a frame summary, with the
// result output register. Depends on ehp_pkg.
`timescale 1ns / 1ps

module ehp_finish (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    sum_valid,
    input  ehp_pkg::frame_summary_t summary,
    output logic                    sum_ready,
    output logic                    res_valid,
    input  logic                    res_ready,
    output ehp_pkg::result_t        result
);

    localparam int FLB = ehp_pkg::FRAME_LENGTH_BITS;
    localparam int CW  = ehp_pkg::CMP_W;

    logic             m_valid_reg, m_valid_next;
    ehp_pkg::result_t result_reg;
    ehp_pkg::result_t res;

    logic           too_short;
    logic [FLB-1:0] l3_raw;
    logic [CW-1:0]  l3, decl_w, hl_w;
    logic [5:0]     hl;
    logic [CW-1:0]  avail4, decl4, avail6;
    logic           v4_ok, v6_ok;

    assign sum_ready = !m_valid_reg || res_ready;

    always_comb begin
        too_short = (summary.cap_len < FLB'(summary.net_start));
        l3_raw    = summary.cap_len - FLB'(summary.net_start);
        l3        = CW'(l3_raw);
        decl_w    = CW'(summary.declared_len);
        hl        = {summary.first_byte[3:0], 2'b00};
        hl_w      = CW'(hl);

        // IPv4 checks and payload span
        v4_ok  = (l3 >= CW'(20)) && (summary.first_byte[7:4] == 4'd4) &&
                 (hl >= 6'd20) && (hl_w <= l3);
        avail4 = l3 - hl_w;
        decl4  = (decl_w > hl_w) ? decl_w - hl_w : '0;

        // IPv6 checks and payload span
        v6_ok  = (l3 >= CW'(40)) && (summary.first_byte[7:4] == 4'd6);
        avail6 = l3 - CW'(40);

        res = '0;
        res.status         = ehp_pkg::ST_REJECT;
        res.network_kind   = ehp_pkg::NET_NONE;
        res.transport_kind = ehp_pkg::TR_NONE;

        if (!too_short) begin
            if (summary.ethertype == ehp_pkg::ETH_IPV4) begin
                if (v4_ok) begin
                    res.status         = ehp_pkg::ST_ACCEPT;
                    res.network_kind   = ehp_pkg::NET_IPV4;
                    res.transport_kind = ehp_pkg::transport_class(summary.protocol);
                    res.ip_protocol    = summary.protocol;
                    res.l4_offset      = 7'(summary.net_start) + 7'(hl);
                    res.l4_length      = (decl4 < avail4) ? decl4[15:0] : avail4[15:0];
                    res.source_low     = {32'd0, summary.src_lo[31:0]};
                    res.dest_low       = {32'd0, summary.dst_lo[31:0]};
                end
            end else if (summary.ethertype == ehp_pkg::ETH_IPV6) begin
                if (v6_ok) begin
                    res.status         = ehp_pkg::ST_ACCEPT;
                    res.network_kind   = ehp_pkg::NET_IPV6;
                    res.transport_kind = ehp_pkg::transport_class(summary.protocol);
                    res.ip_protocol    = summary.protocol;
                    res.l4_offset      = 7'(summary.net_start) + 7'd40;
                    res.l4_length      = (decl_w < avail6) ? decl_w[15:0] : avail6[15:0];
                    res.source_high    = summary.src_hi;
                    res.source_low     = summary.src_lo;
                    res.dest_high      = summary.dst_hi;
                    res.dest_low       = summary.dst_lo;
                end
            end else if (summary.ethertype == ehp_pkg::ETH_ARP) begin
                res.network_kind = ehp_pkg::NET_ARP;
                if (l3 < CW'(28)) begin
                    res.status = ehp_pkg::ST_ARP_SHORT;
                end else begin
                    res.status        = ehp_pkg::ST_ACCEPT;
                    res.source_low    = {32'd0, summary.src_lo[31:0]};
                    res.dest_low      = {32'd0, summary.dst_lo[31:0]};
                    res.arp_operation = summary.arp_op;
                end
            end
        end

        m_valid_next = (m_valid_reg && !res_ready) || sum_valid;
    end

    // Output register: loads whenever it is empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (sum_ready) begin
            m_valid_reg <= m_valid_next;
        end
        if (sum_ready && sum_valid) begin
            result_reg <= res;
        end
    end

    assign res_valid = m_valid_reg;
    assign result    = result_reg;

endmodule
